[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with reset disable.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Clocked next-cycle implication with reset disable.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/sscd_pkg.sv]
// Package with types, constants and helpers of the sector cache directory.
package sscd_pkg;
  localparam int unsigned DefEntries = 64;
  localparam int unsigned SlotW = 6;
  localparam int unsigned CountW = 6;
  localparam logic [CountW-1:0] CountMax = 6'd63;
  localparam int unsigned ScoreW = 11;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned FlushCntW = 7;

  localparam logic [1:0] KindRead   = 2'd0;
  localparam logic [1:0] KindWrite  = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;
  localparam logic [1:0] KindFlush  = 2'd3;

  localparam logic [1:0] CfgAccessWeight = 2'd0;
  localparam logic [1:0] CfgDirtyWeight  = 2'd1;
  localparam logic [1:0] CfgMetaWeight   = 2'd2;
  localparam logic [1:0] CfgInitCount    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sector;
    logic        is_meta;
    logic        full_sector;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic        fill_needed;
    logic        evicted;
    logic        writeback;
    logic [31:0] out_sector;
    logic        last;
  } rsp_t;
endpackage

[src/scored_sector_cache_directory.sv]
// Top level of the scored sector cache directory.
// Channel | Dir | Handshake           | Word
// req     | in  | req_valid/req_ready | request (req_t)
// rsp     | out | rsp_valid/rsp_ready | result (rsp_t)
// cfg     | in  | cfg_valid/cfg_ready | register index and data
// Every request walks all ENTRIES slots through one shared compare and score unit, one slot
// per cycle behind a registered memory read unless a flush walk stalls. A miss with a free
// slot then takes an allocation step before its result.
// A miss on a full cache walks the slots a second time to age them, then allocates.
// A flush walk stalls while a dirty word meets a busy output,
// and every item waits in its last cycle until the output register is free.
// Reset clears the valid bits and state, sets config defaults; entry memory is not cleared.
module scored_sector_cache_directory
  import sscd_pkg::*;
#(
  parameter int unsigned ENTRIES = DefEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] EndIdx = CntW'(ENTRIES);

  typedef enum logic [2:0] {
    StIdle, StLook, StScan, StAge, StAlloc, StFlush, StOut
  } state_e;

  // One directory entry as held in memory.
  typedef struct packed {
    logic [31:0]       tag;
    logic [CountW-1:0] cnt;
    logic              dirty;
    logic              meta;
  } entry_t;

  state_e               state_q;
  req_t                 req_q;
  rsp_t                 res_q;
  logic [CntW-1:0]      idx_q;
  logic [ENTRIES-1:0]   valid_q;
  logic                 found_q, free_found_q, best_found_q;
  logic [IdxW-1:0]      found_idx_q, free_q, best_q;
  entry_t               found_ent_q;
  logic [31:0]          best_tag_q;
  logic                 best_dirty_q;
  logic [ScoreW-1:0]    best_score_q;
  logic [FlushCntW-1:0] nflush_q;
  logic [3:0]           aw_q, dw_q;
  logic [5:0]           mw_q, ic_q;
  rsp_t                 rsp_q;
  logic                 rsp_valid_q;

  // Directory storage, one entry per address.
  entry_t               ent_mem [ENTRIES];
  entry_t               rd_q;
  logic [IdxW-1:0]      rd_addr;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  entry_t               wr_data;

  logic [IdxW-1:0]      ev_idx;
  logic                 ev_vld;
  logic                 cur_valid;
  logic [ScoreW-1:0]    cur_score;
  logic                 out_free;
  logic                 flush_take, flush_stall;
  logic                 rsp_load;
  rsp_t                 rsp_next, scan_rsp, alloc_rsp, flush_rsp;

  // The registered read holds the slot one behind the walk counter.
  assign ev_idx    = IdxW'(idx_q - 1'b1);
  assign ev_vld    = (idx_q != '0);
  assign cur_valid = valid_q[ev_idx];

  // Shared score unit: one multiply and two adds.
  assign cur_score = ScoreW'(rd_q.cnt) * ScoreW'(aw_q)
                   + (rd_q.dirty ? ScoreW'(dw_q) : '0)
                   + (rd_q.meta ? ScoreW'(mw_q) : '0);

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign flush_take  = (state_q == StFlush) && ev_vld && cur_valid && rd_q.dirty
                     && (nflush_q < FlushCntW'(MaxResults));
  assign flush_stall = flush_take && (nflush_q != '0) && !out_free;
  // A stalled flush reads the same slot again so the read data stays put.
  assign rd_addr     = flush_stall ? ev_idx : idx_q[IdxW-1:0];

  assign req_ready_o = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) ent_mem[wr_addr] <= wr_data;
    rd_q <= ent_mem[rd_addr];
  end

  // Memory write port for hits, aging, allocation and flush.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ev_idx;
    wr_data = rd_q;
    unique case (state_q)
      StScan: begin
        if (found_q && req_q.kind != KindRemove) begin
          wr_en   = 1'b1;
          wr_addr = found_idx_q;
          wr_data = found_ent_q;
          if (found_ent_q.cnt != CountMax) wr_data.cnt = found_ent_q.cnt + 1'b1;
          if (req_q.kind == KindWrite) wr_data.dirty = 1'b1;
        end
      end
      StAge: begin
        wr_en = ev_vld;
        if (rd_q.cnt != '0) wr_data.cnt = rd_q.cnt - 1'b1;
      end
      StAlloc: begin
        wr_en         = 1'b1;
        wr_addr       = free_q;
        wr_data.tag   = req_q.sector;
        wr_data.cnt   = (ic_q != CountMax) ? ic_q + 1'b1 : ic_q;
        wr_data.dirty = (req_q.kind == KindWrite);
        wr_data.meta  = (req_q.kind == KindRead) && req_q.is_meta;
      end
      StFlush: begin
        wr_en         = flush_take && !flush_stall;
        wr_data.dirty = 1'b0;
      end
      default: ;
    endcase
  end

  // Result words built by the decide, allocate and flush steps.
  always_comb begin
    scan_rsp = '0;
    if (found_q) begin
      scan_rsp.hit  = 1'b1;
      scan_rsp.slot = SlotW'(found_idx_q);
    end else if (req_q.kind != KindRemove && !free_found_q) begin
      scan_rsp.evicted    = 1'b1;
      scan_rsp.writeback  = best_dirty_q;
      scan_rsp.out_sector = best_tag_q;
    end
    alloc_rsp             = res_q;
    alloc_rsp.slot        = SlotW'(free_q);
    alloc_rsp.fill_needed = (req_q.kind == KindRead) || !req_q.full_sector;
    flush_rsp             = '0;
    flush_rsp.hit         = 1'b1;
    flush_rsp.slot        = SlotW'(ev_idx);
    flush_rsp.writeback   = 1'b1;
    flush_rsp.out_sector  = rd_q.tag;
  end

  // Output load: the final word at the end of an item, or a held flush word
  // once the next dirty entry shows it is not the last.
  always_comb begin
    rsp_load      = 1'b0;
    rsp_next      = res_q;
    rsp_next.last = 1'b1;
    if (state_q == StOut) begin
      rsp_load = out_free;
    end else if (flush_take && !flush_stall && nflush_q != '0) begin
      rsp_load      = 1'b1;
      rsp_next.last = 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= 4'd5;
      dw_q <= 4'd1;
      mw_q <= 6'd32;
      ic_q <= 6'd5;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAccessWeight: aw_q <= cfg_data_i[3:0];
        CfgDirtyWeight:  dw_q <= cfg_data_i[3:0];
        CfgMetaWeight:   mw_q <= cfg_data_i;
        CfgInitCount:    ic_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer, control state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      req_q        <= '0;
      res_q        <= '0;
      idx_q        <= '0;
      valid_q      <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      found_idx_q  <= '0;
      free_q       <= '0;
      best_q       <= '0;
      found_ent_q  <= '0;
      best_tag_q   <= '0;
      best_dirty_q <= 1'b0;
      best_score_q <= '0;
      nflush_q     <= '0;
      rsp_q        <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
        rsp_q       <= rsp_next;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_valid_i) begin
            req_q        <= req_i;
            res_q        <= '0;
            idx_q        <= '0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            best_found_q <= 1'b0;
            nflush_q     <= '0;
            state_q      <= (req_i.kind == KindFlush) ? StFlush : StLook;
          end
        end
        // Walk for a tag match, the first free slot and the best score.
        StLook: begin
          if (ev_vld) begin
            if (cur_valid && rd_q.tag == req_q.sector && !found_q) begin
              found_q     <= 1'b1;
              found_idx_q <= ev_idx;
              found_ent_q <= rd_q;
            end
            if (!cur_valid && !free_found_q) begin
              free_found_q <= 1'b1;
              free_q       <= ev_idx;
            end
            if (cur_valid && (!best_found_q || cur_score < best_score_q)) begin
              best_found_q <= 1'b1;
              best_q       <= ev_idx;
              best_score_q <= cur_score;
              best_tag_q   <= rd_q.tag;
              best_dirty_q <= rd_q.dirty;
            end
          end
          if (idx_q == EndIdx) state_q <= StScan;
          else idx_q <= idx_q + 1'b1;
        end
        // Decide and apply the request.
        StScan: begin
          res_q <= scan_rsp;
          if (req_q.kind == KindRemove) begin
            if (found_q) valid_q[found_idx_q] <= 1'b0;
            state_q <= StOut;
          end else if (found_q) begin
            state_q <= StOut;
          end else if (free_found_q) begin
            state_q <= StAlloc;
          end else begin
            free_q  <= best_q;
            idx_q   <= '0;
            state_q <= StAge;
          end
        end
        // Age every entry on a full-cache miss.
        StAge: begin
          if (idx_q == EndIdx) state_q <= StAlloc;
          else idx_q <= idx_q + 1'b1;
        end
        // Take the chosen slot for the new sector.
        StAlloc: begin
          valid_q[free_q] <= 1'b1;
          res_q           <= alloc_rsp;
          state_q         <= StOut;
        end
        // Flush walk: hold each dirty entry's word until the next one or the end.
        StFlush: begin
          if (!flush_stall) begin
            if (flush_take) begin
              res_q    <= flush_rsp;
              nflush_q <= nflush_q + 1'b1;
            end
            if (idx_q == EndIdx) state_q <= StOut;
            else idx_q <= idx_q + 1'b1;
          end
        end
        // Deliver the final word of the item.
        StOut: begin
          if (out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

[src/sscd_checker.sv]
// Port-level checker of the sector cache directory, with its bind.
`include "assert_macros.svh"
module sscd_checker
  import sscd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input rsp_t rsp_o
);
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o, "ready after accept")
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o), "stalled word changed")
  `ASSERT_IMPL(a_evict_miss, clk_i, rst_ni, rsp_valid_o && rsp_o.evicted, !rsp_o.hit && rsp_o.last, "eviction on hit")
  `ASSERT_IMPL(a_wb_sector, clk_i, rst_ni, rsp_valid_o && rsp_o.writeback && !rsp_o.evicted, rsp_o.hit, "flush word without hit")
endmodule

bind scored_sector_cache_directory sscd_checker u_sscd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i), .req_ready_o(req_ready_o),
  .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
);
